// ===== hdl/kmd_pkg.sv =====
// Package for the key matrix debouncer: defaults, phase codes, register indexes, entry layout.
`default_nettype none
package kmd_pkg;

  localparam int DEF_ROWS = 8;
  localparam int DEF_COLS = 16;

  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int TIME_W  = 32;
  localparam int DBT_W   = 4;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 8;
  localparam int CIDX_W  = 8;
  localparam int CDAT_W  = 8;
  localparam int PHASE_W = 2;
  localparam int ENTRY_W = TIME_W + PHASE_W;

  localparam logic [PHASE_W-1:0] PH_OFF       = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ON        = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASING = 2'd3;

  localparam logic [CIDX_W-1:0] REG_PRESS_TIME   = 8'd0;
  localparam logic [CIDX_W-1:0] REG_RELEASE_TIME = 8'd1;

  localparam logic [DBT_W-1:0] DBT_RESET = 4'd5;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [PHASE_W-1:0] phase;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/kmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire  logic                                   clk,
  input  wire  logic                                   we,
  input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]                       wdata,
  input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic       [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/key_matrix_debounce.sv =====
// Top level of the key matrix debouncer: per-key four-phase state machine held in RAM.
//
// One key sample is taken per cycle, sustained while the output is taken; a held-off output
// stalls the input once the stage and the output register are both full. The debounced flag
// is computed in the stage after acceptance and registered into the output register when
// the output advances. Each key's phase and timestamp live in one RAM entry with a
// registered read: a sample is read in the cycle it is accepted, updated and written back
// when the stage advances, and a one-entry forward path covers a sample of the same key
// that follows directly. After reset a clearing pass sets every key to off; no sample is
// accepted during it, configuration writes are taken as ever.
// s_tdata holds key_row, key_col, raw_level, now_ms; m_tdata holds key_on.
`default_nettype none
module key_matrix_debounce
  import kmd_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              s_tvalid,
  output logic                    s_tready,
  input  wire  logic [IN_W-1:0]   s_tdata,   // key_row[2:0], key_col[6:3], raw_level[7], now_ms[39:8]
  output logic                    m_tvalid,
  input  wire  logic              m_tready,
  output logic       [OUT_W-1:0]  m_tdata,   // key_on[0], zero fill [7:1]
  input  wire  logic              cfg_valid,
  output logic                    cfg_ready,
  input  wire  logic [CIDX_W-1:0] cfg_index,
  input  wire  logic [CDAT_W-1:0] cfg_data
);

  localparam int KEYS = ROWS * COLS;
  localparam int KW   = KEYS > 1 ? $clog2(KEYS) : 1;

  logic [DBT_W-1:0] press_time;
  logic [DBT_W-1:0] release_time;

  logic          clearing;
  logic [KW-1:0] clr_cnt;

  logic              v1;
  logic [KW-1:0]     key1;
  logic              oor1;
  logic              level1;
  logic [TIME_W-1:0] now1;

  logic          fwd_valid;
  logic [KW-1:0] fwd_key;
  entry_t        fwd_data;

  logic          s_accept;
  logic          adv;
  logic [KW-1:0] s_key;
  logic          s_oor;

  logic [ENTRY_W-1:0] rdata;
  entry_t             cur;
  entry_t             upd;
  logic [TIME_W-1:0]  elapsed;
  logic               key_on;
  logic               item_we;

  logic               ram_we;
  logic [KW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [KW-1:0]      ram_raddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_time   <= DBT_RESET;
      release_time <= DBT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PRESS_TIME) begin
        press_time <= cfg_data[DBT_W-1:0];
      end else if (cfg_index == REG_RELEASE_TIME) begin
        release_time <= cfg_data[DBT_W-1:0];
      end
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!v1 || adv);
  assign s_accept = s_tvalid && s_tready;

  assign s_oor = (32'(s_tdata[2:0]) >= 32'(ROWS)) || (32'(s_tdata[6:3]) >= 32'(COLS));
  assign s_key = KW'(32'(s_tdata[2:0]) * 32'(COLS) + 32'(s_tdata[6:3]));

  assign cur     = (fwd_valid && fwd_key == key1) ? fwd_data : entry_t'(rdata);
  assign elapsed = now1 - cur.stamp;

  always_comb begin
    upd = cur;
    unique case (cur.phase)
      PH_OFF: begin
        if (level1) begin
          if (press_time == '0) begin
            upd.phase = PH_ON;
          end else begin
            upd.phase = PH_PRESSING;
            upd.stamp = now1;
          end
        end
      end
      PH_PRESSING: begin
        if (level1) begin
          if (elapsed > TIME_W'(press_time)) begin
            upd.phase = PH_ON;
          end
        end else begin
          upd.phase = PH_OFF;
        end
      end
      PH_ON: begin
        if (!level1) begin
          if (release_time == '0) begin
            upd.phase = PH_OFF;
          end else begin
            upd.phase = PH_RELEASING;
            upd.stamp = now1;
          end
        end
      end
      PH_RELEASING: begin
        if (!level1) begin
          if (elapsed > TIME_W'(release_time)) begin
            upd.phase = PH_OFF;
          end
        end else begin
          upd.phase = PH_ON;
        end
      end
      default: upd = cur;
    endcase
  end

  assign key_on  = !oor1 && (upd.phase == PH_ON || upd.phase == PH_RELEASING);
  assign item_we = v1 && adv && !oor1;

  assign ram_we    = clearing || item_we;
  assign ram_waddr = clearing ? clr_cnt : key1;
  assign ram_wdata = clearing ? ENTRY_W'(0) : ENTRY_W'(upd);
  assign ram_raddr = s_accept ? s_key : key1;

  kmd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(KEYS)
  ) u_state (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (32'(clr_cnt) == KEYS - 1) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_accept) begin
      v1 <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      key1   <= s_key;
      oor1   <= s_oor;
      level1 <= s_tdata[7];
      now1   <= s_tdata[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= item_we;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      fwd_key  <= key1;
      fwd_data <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && adv) begin
      m_tdata <= OUT_W'(key_on);
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_key_matrix_debounce.sv =====
`timescale 1ns / 100ps
// Testbench for the key matrix debouncer: directed table, then random key scans against a debounce predictor.
module tb_key_matrix_debounce;
  import kmd_pkg::*;

  localparam int N_ROWS = DEF_ROWS;
  localparam int N_COLS = DEF_COLS;
  localparam int N_KEYS = N_ROWS * N_COLS;
  localparam int KEY_W = ROW_W + COL_W;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 8;
  localparam int N_PHASES = 7;
  localparam int PHASE_WORDS = 260;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 8'hC3;

  typedef enum logic {STEP_SAMPLE, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e        kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              lvl;
    logic [TIME_W-1:0] now;
    logic              typed;
    logic              want;
    logic [CIDX_W-1:0] idx;
    logic [CDAT_W-1:0] val;
  } plan_row_t;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              lvl;
    logic [TIME_W-1:0] now;
    logic              key_on;
  } flag_exp_t;

  plan_row_t directed_plan [26] = '{
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b0, 32'd0,        1'b1, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b1, 32'd100,      1'b1, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b1, 32'd105,      1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b1, 32'd106,      1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b0, 32'd200,      1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b1, 32'd203,      1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b0, 32'd210,      1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd0, 4'd0,  1'b0, 32'd216,      1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd3, 4'd9,  1'b1, 32'd50,       1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd3, 4'd9,  1'b0, 32'd52,       1'b0, 1'b0, '0, '0},
    // press straddling the 2^32 wrap
    '{STEP_SAMPLE, 3'd7, 4'd15, 1'b1, 32'hFFFFFFFD, 1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd7, 4'd15, 1'b1, 32'h00000003, 1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd7, 4'd15, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, '0, '0},
    // upper nibble ignored, unused index ignored
    '{STEP_CFG,    '0,   '0,    '0,   '0,           '0,   '0,   REG_PRESS_TIME,   8'hF0},
    '{STEP_CFG,    '0,   '0,    '0,   '0,           '0,   '0,   REG_RELEASE_TIME, 8'h00},
    '{STEP_CFG,    '0,   '0,    '0,   '0,           '0,   '0,   REG_UNUSED,       8'h0F},
    '{STEP_SAMPLE, 3'd5, 4'd10, 1'b1, 32'd1234,     1'b1, 1'b1, '0, '0},
    '{STEP_SAMPLE, 3'd5, 4'd10, 1'b0, 32'd1234,     1'b1, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd7, 4'd15, 1'b0, 32'd0,        1'b1, 1'b0, '0, '0},
    '{STEP_CFG,    '0,   '0,    '0,   '0,           '0,   '0,   REG_PRESS_TIME,   8'h0F},
    '{STEP_CFG,    '0,   '0,    '0,   '0,           '0,   '0,   REG_RELEASE_TIME, 8'hFF},
    '{STEP_SAMPLE, 3'd2, 4'd4,  1'b1, 32'hAAAAAAAA, 1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd2, 4'd4,  1'b1, 32'hAAAAAAB9, 1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd2, 4'd4,  1'b1, 32'hAAAAAABA, 1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd2, 4'd4,  1'b0, 32'h55555555, 1'b0, 1'b0, '0, '0},
    '{STEP_SAMPLE, 3'd2, 4'd4,  1'b0, 32'h55555565, 1'b0, 1'b0, '0, '0}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;   // key_row[2:0], key_col[6:3], raw_level[7], now_ms[39:8]
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // key_on[0], zero fill [7:1]
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CDAT_W-1:0] cfg_data;

  logic [PHASE_W-1:0] phase_m [N_KEYS];
  logic [TIME_W-1:0]  stamp_m [N_KEYS];
  logic               active_m [N_KEYS];
  logic [DBT_W-1:0]   press_ms;
  logic [DBT_W-1:0]   release_ms;

  flag_exp_t   pending_flags [$];
  int          errors = 0;
  int unsigned cycles = 0;
  logic        idle_on;
  int          hold_reqs;

  key_matrix_debounce #(
    .ROWS(N_ROWS),
    .COLS(N_COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic debounce_update(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col,
                                           input logic lvl,
                                           input logic [TIME_W-1:0] now);
    int k;
    logic [TIME_W-1:0] elapsed;
    if (int'(row) >= N_ROWS || int'(col) >= N_COLS) return 1'b0;
    k = int'(row) * N_COLS + int'(col);
    elapsed = now - stamp_m[k];
    case (phase_m[k])
      PH_OFF: if (lvl) begin
        if (press_ms == '0) begin
          phase_m[k] = PH_ON;
          active_m[k] = 1'b1;
        end else begin
          phase_m[k] = PH_PRESSING;
          stamp_m[k] = now;
        end
      end
      PH_PRESSING: if (!lvl) begin
        phase_m[k] = PH_OFF;
      end else if (elapsed > TIME_W'(press_ms)) begin
        phase_m[k] = PH_ON;
        active_m[k] = 1'b1;
      end
      PH_ON: if (!lvl) begin
        if (release_ms == '0) begin
          phase_m[k] = PH_OFF;
          active_m[k] = 1'b0;
        end else begin
          phase_m[k] = PH_RELEASING;
          stamp_m[k] = now;
        end
      end
      default: if (lvl) begin
        phase_m[k] = PH_ON;
      end else if (elapsed > TIME_W'(release_ms)) begin
        phase_m[k] = PH_OFF;
        active_m[k] = 1'b0;
      end
    endcase
    return active_m[k];
  endfunction

  task automatic send_sample(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic lvl, input logic [TIME_W-1:0] now,
                             input logic typed, input logic want);
    flag_exp_t e;
    logic flag;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {now, lvl, col, row};
    do @(posedge clk); while (!s_tready);
    flag = debounce_update(row, col, lvl, now);
    e.row = row;
    e.col = col;
    e.lvl = lvl;
    e.now = now;
    e.key_on = typed ? want : flag;
    pending_flags.push_back(e);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PRESS_TIME) press_ms = val[DBT_W-1:0];
    else if (idx == REG_RELEASE_TIME) release_ms = val[DBT_W-1:0];
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_out
    flag_exp_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: expected no word, got %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending_flags.pop_front();
        if (m_tdata !== {{(OUT_W-1){1'b0}}, e.key_on}) begin
          $display("%0t: key r%0d c%0d lvl %0b at %0h ms: expected %h, got %h", $time,
                   e.row, e.col, e.lvl, e.now, {{(OUT_W-1){1'b0}}, e.key_on}, m_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]  hot [4];
    logic              held [N_KEYS];
    logic [KEY_W-1:0]  kk;
    logic              lvl;
    logic [TIME_W-1:0] ms_now;
    logic [TIME_W-1:0] t;
    logic [DBT_W-1:0]  pt;
    logic [DBT_W-1:0]  rt;
    logic [3:0]        junk;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    idle_on <= 1'b1;
    hold_reqs <= 0;
    press_ms = DBT_RESET;
    release_ms = DBT_RESET;
    for (int i = 0; i < N_KEYS; i++) begin
      phase_m[i] = PH_OFF;
      stamp_m[i] = '0;
      active_m[i] = 1'b0;
      held[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_CFG) begin
        write_reg(directed_plan[i].idx, directed_plan[i].val);
      end else begin
        send_sample(directed_plan[i].row, directed_plan[i].col, directed_plan[i].lvl,
                    directed_plan[i].now, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin pt = 4'd15; rt = 4'd15; end
        1: begin pt = 4'd0;  rt = 4'd0;  end
        2: begin pt = 4'd0;  rt = 4'd15; end
        3: begin pt = 4'd15; rt = 4'd0;  end
        5: begin pt = 4'd1;  rt = 4'd1;  end
        default: begin
          pt = DBT_W'($urandom);
          rt = DBT_W'($urandom);
        end
      endcase
      junk = 4'($urandom);
      write_reg(REG_PRESS_TIME, {junk, pt});
      junk = 4'($urandom);
      write_reg(REG_RELEASE_TIME, {junk, rt});
      if (ph == 4) write_reg(CIDX_W'($urandom_range(2, 255)), CDAT_W'($urandom));
      if (ph == 1) hold_reqs <= hold_reqs + 1;
      if (ph == N_PHASES - 1) idle_on <= 1'b0;
      ms_now = (ph == 2) ? 32'hFFFFFF00 : $urandom;
      for (int j = 0; j < 4; j++) hot[j] = KEY_W'($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 63) == 0) hot[$urandom_range(0, 3)] = KEY_W'($urandom);
        ms_now += $urandom_range(0, 3);
        if ($urandom_range(0, 99) == 0) ms_now += $urandom;
        if ($urandom_range(0, 15) == 0) begin
          // stray sample: any key, any level, any time
          kk = KEY_W'($urandom);
          lvl = 1'($urandom);
          t = $urandom;
        end else begin
          kk = hot[$urandom_range(0, 3)];
          if ($urandom_range(0, 29) == 0) held[kk] = ~held[kk];
          lvl = held[kk] ^ ($urandom_range(0, 6) == 0);
          t = ms_now;
        end
        send_sample(kk[COL_W +: ROW_W], kk[COL_W-1:0], lvl, t, 1'b0, 1'b0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_flags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kmd_pkg.sv
hdl/kmd_ram.sv
hdl/key_matrix_debounce.sv
verif/tb_key_matrix_debounce.sv
